@@ design/ubm_pkg.sv @@
package ubm_pkg;

  // Register indexes on the configuration port
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_QUARTER_BIT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STANDBY_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STANDBY_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_LOW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTE  = 3'd4;
  localparam int unsigned CFG_DATA_W = 16;

  // Command codes
  localparam logic [2:0] CMD_NONE    = 3'd0;
  localparam logic [2:0] CMD_STANDBY = 3'd1;
  localparam logic [2:0] CMD_HEADER  = 3'd2;
  localparam logic [2:0] CMD_SEND    = 3'd3;
  localparam logic [2:0] CMD_RECEIVE = 3'd4;

  // Bit counter marks: data bits 0..7, master ack 8, slave ack 9
  localparam logic [3:0] BIT_LAST_DATA = 4'd7;
  localparam logic [3:0] BIT_MAK       = 4'd8;
  localparam logic [3:0] BIT_SAK       = 4'd9;

  localparam logic [7:0] BYTE_MSB = 8'h80;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_STBY_LO = 3'd1,
    PH_STBY_HI = 3'd2,
    PH_HDR_LO  = 3'd3,
    PH_Q0      = 3'd4,
    PH_Q1      = 3'd5,
    PH_Q2      = 3'd6,
    PH_Q3      = 3'd7
  } phase_e;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] tx_byte;
    logic       mak_bit;
    logic       line_in;
  } ubm_in_t;

  typedef struct packed {
    logic       drive_enable;
    logic       drive_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       slave_ack;
  } ubm_out_t;

  typedef struct packed {
    logic [15:0] quarter_bit_ticks;
    logic [15:0] standby_low_ticks;
    logic [15:0] standby_high_ticks;
    logic [15:0] header_low_ticks;
    logic [7:0]  header_byte;
  } ubm_cfg_t;

endpackage

@@ design/ubm_seq.sv @@
module ubm_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  ubm_pkg::ubm_in_t  item_i,
  input  ubm_pkg::ubm_cfg_t cfg_i,
  output ubm_pkg::ubm_out_t res_o
);

  ubm_pkg::phase_e phase_q, phase_d, ph_e;
  logic [15:0] tick_q, tick_d, tick_e;
  logic [3:0]  bit_q, bit_d, bit_e;
  logic [7:0]  shift_q, shift_d, shift_e;
  logic        fs_q, fs_d;
  logic        ack_q, ack_d;
  logic        rm_q, rm_d, rm_e;
  logic        mak_q, mak_d, mak_e;
  logic        hdr_q, hdr_d, hdr_e;
  logic [7:0]  rx_q, rx_d;
  logic [15:0] len;
  logic        last;
  logic        bitval;
  logic        en;
  logic        lvl;
  logic        done;
  logic [7:0]  shift_nx;

  // Start a new command when idle
  always_comb begin
    ph_e    = phase_q;
    tick_e  = tick_q;
    bit_e   = bit_q;
    shift_e = shift_q;
    rm_e    = rm_q;
    mak_e   = mak_q;
    hdr_e   = hdr_q;
    if (phase_q == ubm_pkg::PH_IDLE) begin
      tick_e = '0;
      unique case (item_i.command)
        ubm_pkg::CMD_STANDBY: ph_e = ubm_pkg::PH_STBY_LO;
        ubm_pkg::CMD_HEADER: begin
          ph_e    = ubm_pkg::PH_HDR_LO;
          shift_e = cfg_i.header_byte;
          rm_e    = 1'b0;
          mak_e   = 1'b1;
          hdr_e   = 1'b1;
          bit_e   = '0;
        end
        ubm_pkg::CMD_SEND: begin
          ph_e    = ubm_pkg::PH_Q0;
          shift_e = item_i.tx_byte;
          rm_e    = 1'b0;
          mak_e   = item_i.mak_bit;
          hdr_e   = 1'b0;
          bit_e   = '0;
        end
        ubm_pkg::CMD_RECEIVE: begin
          ph_e    = ubm_pkg::PH_Q0;
          shift_e = '0;
          rm_e    = 1'b1;
          mak_e   = item_i.mak_bit;
          hdr_e   = 1'b0;
          bit_e   = '0;
        end
        default: ;
      endcase
    end
  end

  // Line drive and segment length for the current phase
  always_comb begin
    en     = 1'b0;
    lvl    = 1'b0;
    bitval = 1'b1;
    len    = 16'd1;
    unique case (ph_e) inside
      ubm_pkg::PH_STBY_LO: begin
        en  = 1'b1;
        len = cfg_i.standby_low_ticks;
      end
      ubm_pkg::PH_STBY_HI: begin
        en  = 1'b1;
        lvl = 1'b1;
        len = cfg_i.standby_high_ticks;
      end
      ubm_pkg::PH_HDR_LO: begin
        en  = 1'b1;
        len = cfg_i.header_low_ticks;
      end
      ubm_pkg::PH_Q0, ubm_pkg::PH_Q1, ubm_pkg::PH_Q2, ubm_pkg::PH_Q3: begin
        len = cfg_i.quarter_bit_ticks;
        if (bit_e < ubm_pkg::BIT_MAK) begin
          bitval = rm_e ? 1'b1 : ((shift_e & ubm_pkg::BYTE_MSB) != 8'h00);
          en     = !rm_e;
        end else if (bit_e == ubm_pkg::BIT_MAK) begin
          bitval = mak_e;
          en     = 1'b1;
        end
        // inverted bit in the first half, true bit in the second
        if (en) begin
          lvl = (ph_e == ubm_pkg::PH_Q0 || ph_e == ubm_pkg::PH_Q1) ? !bitval : bitval;
        end
      end
      default: ;
    endcase
  end

  // A zero length compares as one tick
  assign last = ({1'b0, tick_e} + 17'd1) >= {1'b0, len};
  assign shift_nx = {shift_e[6:0], (rm_e ? fs_q : 1'b0)};

  // Advance the sequencer by one tick
  always_comb begin
    phase_d = ph_e;
    tick_d  = tick_e;
    bit_d   = bit_e;
    shift_d = shift_e;
    rm_d    = rm_e;
    mak_d   = mak_e;
    hdr_d   = hdr_e;
    fs_d    = fs_q;
    ack_d   = ack_q;
    rx_d    = rx_q;
    done    = 1'b0;
    if (ph_e != ubm_pkg::PH_IDLE) begin
      if (!last) begin
        tick_d = tick_e + 16'd1;
      end else begin
        tick_d = '0;
        unique case (ph_e)
          ubm_pkg::PH_STBY_LO: phase_d = ubm_pkg::PH_STBY_HI;
          ubm_pkg::PH_STBY_HI: begin
            phase_d = ubm_pkg::PH_IDLE;
            done    = 1'b1;
          end
          ubm_pkg::PH_HDR_LO: begin
            phase_d = ubm_pkg::PH_Q0;
            bit_d   = '0;
          end
          ubm_pkg::PH_Q0: begin
            fs_d    = item_i.line_in;
            phase_d = ubm_pkg::PH_Q1;
          end
          ubm_pkg::PH_Q1: phase_d = ubm_pkg::PH_Q2;
          ubm_pkg::PH_Q2: begin
            fs_d    = !fs_q && item_i.line_in;
            phase_d = ubm_pkg::PH_Q3;
          end
          ubm_pkg::PH_Q3: begin
            if (bit_e < ubm_pkg::BIT_MAK) begin
              shift_d = shift_nx;
              if (bit_e == ubm_pkg::BIT_LAST_DATA && rm_e) begin
                rx_d = shift_nx;
              end
            end
            if (bit_e >= ubm_pkg::BIT_SAK) begin
              if (!hdr_e) begin
                ack_d = fs_q;
              end
              phase_d = ubm_pkg::PH_IDLE;
              done    = 1'b1;
            end else begin
              bit_d   = bit_e + 4'd1;
              phase_d = ubm_pkg::PH_Q0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Hold state between ticks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ubm_pkg::PH_IDLE;
      tick_q  <= '0;
      bit_q   <= '0;
      shift_q <= '0;
      fs_q    <= 1'b0;
      ack_q   <= 1'b0;
      rm_q    <= 1'b0;
      mak_q   <= 1'b0;
      hdr_q   <= 1'b0;
      rx_q    <= '0;
    end else if (adv_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      fs_q    <= fs_d;
      ack_q   <= ack_d;
      rm_q    <= rm_d;
      mak_q   <= mak_d;
      hdr_q   <= hdr_d;
      rx_q    <= rx_d;
    end
  end

  assign res_o.drive_enable = en;
  assign res_o.drive_level  = lvl;
  assign res_o.busy_res     = (ph_e != ubm_pkg::PH_IDLE);
  assign res_o.done_res     = done;
  assign res_o.rx_byte      = rx_d;
  assign res_o.slave_ack    = ack_d;

endmodule

@@ design/unio_bus_master.sv @@
// Single-wire Manchester bus master, one tick per transfer.
// A tick is held in the input register, then its result in the result register.
// Throughput: one tick per cycle while out_ready_i takes each result;
// the sequencer step sits between the two registers.
// Reset: asynchronous, active low; sequencer idle, configuration at defaults.
module unio_bus_master (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  ubm_pkg::ubm_in_t                    in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output ubm_pkg::ubm_out_t                   out_data_o,
  input  logic                                cfg_we_i,
  input  logic [ubm_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [ubm_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  ubm_pkg::ubm_cfg_t cfg_q;
  ubm_pkg::ubm_in_t  in_q;
  logic              in_vld_q;
  ubm_pkg::ubm_out_t res;
  ubm_pkg::ubm_out_t out_q;
  logic              out_vld_q;
  logic              move;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.quarter_bit_ticks  <= 16'd5;
      cfg_q.standby_low_ticks  <= 16'd10;
      cfg_q.standby_high_ticks <= 16'd600;
      cfg_q.header_low_ticks   <= 16'd5;
      cfg_q.header_byte        <= 8'h55;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ubm_pkg::CFG_QUARTER_BIT:  cfg_q.quarter_bit_ticks  <= cfg_data_i;
        ubm_pkg::CFG_STANDBY_LOW:  cfg_q.standby_low_ticks  <= cfg_data_i;
        ubm_pkg::CFG_STANDBY_HIGH: cfg_q.standby_high_ticks <= cfg_data_i;
        ubm_pkg::CFG_HEADER_LOW:   cfg_q.header_low_ticks   <= cfg_data_i;
        ubm_pkg::CFG_HEADER_BYTE:  cfg_q.header_byte        <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Step the held tick when the result register can take it
  assign move       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || move;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  ubm_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (move),
    .item_i (in_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (move) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

@@ design/ubm_checker.sv @@
module ubm_assertions (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input ubm_pkg::ubm_in_t               in_data_i,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input ubm_pkg::ubm_out_t              out_data_o,
  input logic                           cfg_we_i,
  input logic [ubm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input logic [ubm_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // A released line carries no level
  a_release_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.drive_enable |-> !out_data_o.drive_level)
    else $error("level driven while line released");

  // The finishing tick belongs to the command
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.done_res |-> out_data_o.busy_res)
    else $error("done without busy");

  // No result on the cycle after reset is seen
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid after reset");

endmodule

bind unio_bus_master ubm_assertions u_ubm_checker (.*);
